// ===== rtl/core/dcpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpid_pkg
// Shared types and constants of the dual-channel PID controller.
// ----------------------------------------------------------------------------
package dcpid_pkg;

   // Default number of control channels.
   localparam int CHANNEL_COUNT_DEF = 2;

   // Depth of the frequency history.
   localparam int WINDOW_DEPTH = 4;

   // Field widths.
   localparam int DATA_W  = 32;
   localparam int FREQ_W  = 31;
   localparam int INTEG_W = 48;
   localparam int DRIVE_W = 16;

   // Bit-serial arithmetic unit widths.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 48;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 32;

   // Largest frequency step, 1000 in Q15.16, that is not a glitch.
   localparam logic [FREQ_W-1:0] GLITCH_LIMIT = FREQ_W'(1000 * 65536);

   // Divisor that scales a frequency error.
   localparam logic [DIV_D_W-1:0] FREQ_SCALE = DIV_D_W'(500);

   // 100 percent in Q32.32.
   localparam logic signed [63:0] Q32_100 = 64'sh0000_0064_0000_0000;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_KP_A = 3'd0,
      CSR_KI_A = 3'd1,
      CSR_KD_A = 3'd2,
      CSR_KP_B = 3'd3,
      CSR_KI_B = 3'd4,
      CSR_KD_B = 3'd5,
      CSR_MODE = 3'd6
   } csr_index_type;

   // Item opcodes.
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_NORMAL     = 2'd0,
      ST_PRIMED     = 2'd1,
      ST_NO_FREQ    = 2'd2,
      ST_RESET_DONE = 2'd3
   } status_type;

   // Control of the frequency history.
   typedef struct packed {
      logic push;
      logic clear;
   } win_ctl_type;

   // What the frequency history reports.
   typedef struct packed {
      logic [FREQ_W-1:0] newest;
      logic              empty;
   } win_status_type;

endpackage

// ===== rtl/core/dcpid_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpid_window
// Four-deep frequency history with glitch rejection.
// ----------------------------------------------------------------------------
module dcpid_window (
   input  logic                            clock,
   input  logic                            reset,
   input  dcpid_pkg::win_ctl_type          ctl,
   input  logic [dcpid_pkg::FREQ_W-1:0]    reading,
   output dcpid_pkg::win_status_type       stat
);
   import dcpid_pkg::*;

   logic [FREQ_W-1:0] win_ff [WINDOW_DEPTH];
   logic [FREQ_W-1:0] win_in [WINDOW_DEPTH];

   function automatic logic [FREQ_W-1:0] abs_diff(input logic [FREQ_W-1:0] a,
                                                  input logic [FREQ_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // Clear the history, or shift in the newest reading, then repair or drop a glitch.
   always_comb begin
      win_in = win_ff;
      if (ctl.clear) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) win_in[i] = '0;
      end else if (ctl.push) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = win_ff[3];
         win_in[3] = reading;
         if (win_in[0] != '0 && abs_diff(win_in[3], win_in[2]) > GLITCH_LIMIT) begin
            if (abs_diff(win_in[2], win_in[1]) < GLITCH_LIMIT) begin
               win_in[3] = win_in[2];
            end else if (abs_diff(win_in[1], win_in[0]) < GLITCH_LIMIT) begin
               win_in[3] = win_in[1];
               win_in[2] = win_in[1];
            end else begin
               for (int i = 0; i < WINDOW_DEPTH; i++) win_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) win_ff[i] <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign stat.newest = win_ff[WINDOW_DEPTH-1];
   assign stat.empty  = (win_ff[0] == '0);

endmodule

// ===== rtl/core/dcpid_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpid_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dcpid_mul #(
   parameter int A_W = dcpid_pkg::MUL_A_W,
   parameter int B_W = dcpid_pkg::MUL_B_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);
   import dcpid_pkg::*;

   localparam int CNT_W = (A_W > 1) ? $clog2(A_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [B_W-1:0]   b_ff;
   logic [B_W-1:0]   hi_ff;
   logic [A_W-1:0]   lo_ff;
   logic [B_W:0]     sum;

   // Add the multiplicand when the current multiplier bit is set.
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, b_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(A_W - 1);
            hi_ff   <= '0;
            lo_ff   <= a;
            b_ff    <= b;
         end else if (busy_ff) begin
            hi_ff  <= sum[B_W:1];
            lo_ff  <= {sum[0], lo_ff[A_W-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) busy_ff <= 1'b0;
         end
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== rtl/core/dcpid_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpid_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcpid_div #(
   parameter int N_W = dcpid_pkg::DIV_N_W,
   parameter int D_W = dcpid_pkg::DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);
   import dcpid_pkg::*;

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [D_W-1:0]   d_ff;
   logic [D_W-1:0]   rem_ff;
   logic [N_W-1:0]   q_ff;
   logic [D_W:0]     shifted;
   logic [D_W:0]     trial;
   logic             fits;

   // Bring down the next dividend bit and try the subtraction.
   assign shifted = {rem_ff, q_ff[N_W-1]};
   assign trial   = shifted - {1'b0, d_ff};
   assign fits    = (shifted >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(N_W - 1);
            rem_ff  <= '0;
            q_ff    <= dividend;
            d_ff    <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
            q_ff   <= {q_ff[N_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) busy_ff <= 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/core/dual_channel_pid_with_glitch_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_pid_with_glitch_filter
// Two-channel time-normalized PID controller with a frequency glitch filter.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one item at a time: a channel clear or a control
//   sample. The rsp_ channel returns exactly one item (drive, status) for each.
//   req_stall is high from acceptance until the result enters the output
//   register; the output register holds a result while rsp_stall is high and
//   the next item is accepted meanwhile.
//   From acceptance to rsp_valid, a clear or an out-of-range item goes
//   straight to the result stage; priming first forms the error, with one
//   divider pass in frequency mode. A full control sample takes up to three
//   passes of the shared 64-step divider, four in frequency mode, and five
//   passes of the shared 32-step multiplier. A skipped integral cap saves
//   one divider pass and a zero interval saves one multiplier pass and one
//   divider pass. The next item can be accepted in the same cycle as the
//   result of the previous one appears.
//   Reset clears the gains, the mode bits, both channels and the frequency
//   history; there is no clearing pass. csr_ writes take effect at once;
//   they are to be made while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module dual_channel_pid_with_glitch_filter #(
   parameter int CHANNEL_COUNT = dcpid_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic                                   req_channel,
   input  logic signed [dcpid_pkg::DATA_W-1:0]    req_measurement,
   input  logic signed [dcpid_pkg::DATA_W-1:0]    req_setpoint,
   input  logic        [dcpid_pkg::FREQ_W-1:0]    req_freq_reading,
   input  logic        [dcpid_pkg::DATA_W-1:0]    req_time_stamp,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dcpid_pkg::DRIVE_W-1:0]   rsp_drive,
   output logic        [1:0]                      rsp_status,
   input  logic                                   csr_wr_en,
   input  logic        [2:0]                      csr_index,
   input  logic        [dcpid_pkg::DATA_W-1:0]    csr_wdata
);
   import dcpid_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_ERR, S_ERR_DIV, S_CHECK, S_INC_MUL, S_INC_DIV, S_INC_ADD,
      S_CAP, S_CAP_DIV, S_UNI, S_DER, S_DER_MUL, S_DER_DIV, S_KP, S_KI, S_KD,
      S_SUM, S_DONE
   } state_type;

   localparam logic [47:0] MAG47    = 48'h8000_0000_0000;
   localparam logic [47:0] MAG47_M1 = 48'h7FFF_FFFF_FFFF;

   // Configuration registers.
   logic signed [DATA_W-1:0] kp_a_ff, ki_a_ff, kd_a_ff, kp_b_ff, ki_b_ff, kd_b_ff;
   logic [3:0]               mode_ff;

   // Channel state.
   logic signed [INTEG_W-1:0] integ_st_ff  [CHANNEL_COUNT];
   logic signed [DATA_W-1:0]  perr_st_ff   [CHANNEL_COUNT];
   logic        [DATA_W-1:0]  ptime_st_ff  [CHANNEL_COUNT];
   logic        [DATA_W-1:0]  norm_st_ff   [CHANNEL_COUNT];
   logic                      primed_st_ff [CHANNEL_COUNT];

   // Working registers of the current item.
   state_type                  state_ff;
   logic                       ch_ff;
   logic signed [DATA_W-1:0]   meas_ff, setp_ff;
   logic        [DATA_W-1:0]   now_ff;
   logic signed [DATA_W-1:0]   err_ff;
   logic        [DATA_W-1:0]   dt_ff, nrm_ff;
   logic        [INTEG_W-1:0]  inc_mag_ff;
   logic signed [INTEG_W-1:0]  integ_ff, der_ff;
   logic signed [63:0]         acc_ff;
   logic                       mneg_ff;
   logic signed [DRIVE_W-1:0]  res_drive_ff;
   status_type                 res_status_ff;
   logic                       rsp_valid_ff;
   logic signed [DRIVE_W-1:0]  rsp_drive_ff;
   status_type                 rsp_status_ff;

   // Arithmetic unit requests.
   logic                  mul_start_ff, div_start_ff;
   logic [MUL_A_W-1:0]    mul_a_ff;
   logic [MUL_B_W-1:0]    mul_b_ff;
   logic [DIV_N_W-1:0]    div_n_ff;
   logic [DIV_D_W-1:0]    div_d_ff;
   logic                  mul_done, div_done;
   logic [MUL_P_W-1:0]    mul_p;
   logic [DIV_N_W-1:0]    div_q;

   win_ctl_type           win_ctl;
   win_status_type        win_stat;

   // Combinational helpers.
   logic                      accept, ch_ok, fmode, bipolar;
   logic signed [DATA_W-1:0]  kp_sel, ki_sel, kd_sel;
   logic        [DATA_W-1:0]  err_abs, ki_abs, kp_abs, kd_abs;
   logic        [32:0]        fdiff, fmag, tdiff, ddiff, dmag;
   logic signed [DATA_W-1:0]  err_temp;
   logic        [DATA_W-1:0]  dt_now, nrm_pick;
   logic        [48:0]        isum;
   logic signed [INTEG_W-1:0] integ_add;
   logic        [INTEG_W-1:0] integ_abs, der_abs;
   logic signed [63:0]        prod_sat, acc_clamp, acc_mag;
   logic        [14:0]        drive_mag;
   logic signed [DRIVE_W-1:0] drive_val;

   function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [INTEG_W-1:0] abs48(input logic signed [INTEG_W-1:0] v);
      return v[INTEG_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Product magnitude capped at 2^61, then signed.
   function automatic logic signed [63:0] sat61(input logic [MUL_P_W-1:0] p,
                                                 input logic neg);
      logic        over;
      logic [63:0] m;
      over = (|p[MUL_P_W-1:62]) || (p[61] && (|p[60:0]));
      m    = over ? 64'h2000_0000_0000_0000 : {2'b00, p[61:0]};
      return neg ? -$signed(m) : $signed(m);
   endfunction

   dcpid_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .reading (req_freq_reading),
      .stat    (win_stat)
   );

   dcpid_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   dcpid_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Handshake and frequency history control.
   assign req_stall     = (state_ff != S_IDLE);
   assign accept        = req_valid && (state_ff == S_IDLE);
   assign ch_ok         = (int'(req_channel) < CHANNEL_COUNT);
   assign win_ctl.push  = accept && (req_opcode == OP_SAMPLE) && ch_ok;
   assign win_ctl.clear = accept && (req_opcode == OP_CLEAR) && ch_ok;

   // Channel selection and the datapath between the arithmetic units.
   always_comb begin
      kp_sel  = ch_ff ? kp_b_ff : kp_a_ff;
      ki_sel  = ch_ff ? ki_b_ff : ki_a_ff;
      kd_sel  = ch_ff ? kd_b_ff : kd_a_ff;
      fmode   = mode_ff[{1'b0, ch_ff}];
      bipolar = mode_ff[{1'b1, ch_ff}];
      err_abs = abs32(err_ff);
      kp_abs  = abs32(kp_sel);
      ki_abs  = abs32(ki_sel);
      kd_abs  = abs32(kd_sel);

      // Frequency error before the scaling division.
      fdiff = {2'b00, win_stat.newest} - {setp_ff[DATA_W-1], setp_ff};
      fmag  = fdiff[32] ? (~fdiff + 1'b1) : fdiff;

      // Temperature error, saturated to 32 bits.
      tdiff = {meas_ff[DATA_W-1], meas_ff} - {setp_ff[DATA_W-1], setp_ff};
      if (tdiff[32] != tdiff[31]) begin
         err_temp = tdiff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         err_temp = $signed(tdiff[31:0]);
      end

      dt_now   = now_ff - ptime_st_ff[ch_ff];
      nrm_pick = (norm_st_ff[ch_ff] == '0) ? dt_now : norm_st_ff[ch_ff];

      // Integral plus increment, saturated to 48 bits.
      isum = {integ_ff[INTEG_W-1], integ_ff} +
             (err_ff[DATA_W-1] ? (~{1'b0, inc_mag_ff} + 1'b1) : {1'b0, inc_mag_ff});
      if (isum[48] != isum[47]) begin
         integ_add = isum[48] ? $signed(MAG47) : $signed(MAG47_M1);
      end else begin
         integ_add = $signed(isum[47:0]);
      end
      integ_abs = abs48(integ_ff);
      der_abs   = abs48(der_ff);

      // Change of error since the last sample.
      ddiff = {err_ff[DATA_W-1], err_ff} -
              {perr_st_ff[ch_ff][DATA_W-1], perr_st_ff[ch_ff]};
      dmag  = ddiff[32] ? (~ddiff + 1'b1) : ddiff;

      prod_sat = sat61(mul_p, mneg_ff);

      // Limit to +-100 percent and convert to Q8.8.
      if (acc_ff > Q32_100) begin
         acc_clamp = Q32_100;
      end else if (acc_ff < -Q32_100) begin
         acc_clamp = -Q32_100;
      end else begin
         acc_clamp = acc_ff;
      end
      acc_mag   = acc_clamp[63] ? -acc_clamp : acc_clamp;
      drive_mag = acc_mag[38:24];
      drive_val = (acc_clamp[63] ^ fmode) ? -$signed({1'b0, drive_mag})
                                          : $signed({1'b0, drive_mag});
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_a_ff <= '0;
         ki_a_ff <= '0;
         kd_a_ff <= '0;
         kp_b_ff <= '0;
         ki_b_ff <= '0;
         kd_b_ff <= '0;
         mode_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KP_A: kp_a_ff <= $signed(csr_wdata);
            CSR_KI_A: ki_a_ff <= $signed(csr_wdata);
            CSR_KD_A: kd_a_ff <= $signed(csr_wdata);
            CSR_KP_B: kp_b_ff <= $signed(csr_wdata);
            CSR_KI_B: ki_b_ff <= $signed(csr_wdata);
            CSR_KD_B: kd_b_ff <= $signed(csr_wdata);
            CSR_MODE: mode_ff <= csr_wdata[3:0];
            default:  ;
         endcase
      end
   end

   // Sequencer, channel state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            integ_st_ff[i]  <= '0;
            perr_st_ff[i]   <= '0;
            ptime_st_ff[i]  <= '0;
            norm_st_ff[i]   <= '0;
            primed_st_ff[i] <= 1'b0;
         end
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ch_ff        <= req_channel;
                  meas_ff      <= req_measurement;
                  setp_ff      <= req_setpoint;
                  now_ff       <= req_time_stamp;
                  res_drive_ff <= '0;
                  if (req_opcode == OP_CLEAR) begin
                     if (ch_ok) begin
                        integ_st_ff[req_channel]  <= '0;
                        perr_st_ff[req_channel]   <= '0;
                        ptime_st_ff[req_channel]  <= '0;
                        norm_st_ff[req_channel]   <= '0;
                        primed_st_ff[req_channel] <= 1'b0;
                     end
                     res_status_ff <= ST_RESET_DONE;
                     state_ff      <= S_DONE;
                  end else if (!ch_ok) begin
                     res_status_ff <= ST_NORMAL;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_ERR;
                  end
               end
            end

            // Error from temperature, or frequency scaled by a division.
            S_ERR: begin
               if (fmode) begin
                  div_start_ff <= 1'b1;
                  div_n_ff     <= {31'd0, fmag};
                  div_d_ff     <= FREQ_SCALE;
                  mneg_ff      <= fdiff[32];
                  state_ff     <= S_ERR_DIV;
               end else begin
                  err_ff   <= err_temp;
                  state_ff <= S_CHECK;
               end
            end

            S_ERR_DIV: begin
               if (div_done) begin
                  err_ff   <= mneg_ff ? -$signed(div_q[DATA_W-1:0])
                                      : $signed(div_q[DATA_W-1:0]);
                  state_ff <= S_CHECK;
               end
            end

            // Missing frequency, priming, or the start of the full update.
            S_CHECK: begin
               if (fmode && win_stat.empty) begin
                  res_status_ff <= ST_NO_FREQ;
                  state_ff      <= S_DONE;
               end else if (!primed_st_ff[ch_ff]) begin
                  ptime_st_ff[ch_ff]  <= now_ff;
                  perr_st_ff[ch_ff]   <= err_ff;
                  primed_st_ff[ch_ff] <= 1'b1;
                  res_status_ff       <= ST_PRIMED;
                  state_ff            <= S_DONE;
               end else begin
                  dt_ff      <= dt_now;
                  nrm_ff     <= nrm_pick;
                  integ_ff   <= integ_st_ff[ch_ff];
                  inc_mag_ff <= '0;
                  if (nrm_pick != '0) begin
                     mul_start_ff <= 1'b1;
                     mul_a_ff     <= dt_now;
                     mul_b_ff     <= {16'd0, err_abs};
                     state_ff     <= S_INC_MUL;
                  end else begin
                     state_ff <= S_INC_ADD;
                  end
               end
            end

            S_INC_MUL: begin
               if (mul_done) begin
                  div_start_ff <= 1'b1;
                  div_n_ff     <= mul_p[DIV_N_W-1:0];
                  div_d_ff     <= nrm_ff;
                  state_ff     <= S_INC_DIV;
               end
            end

            S_INC_DIV: begin
               if (div_done) begin
                  inc_mag_ff <= (div_q > {16'd0, MAG47}) ? MAG47 : div_q[INTEG_W-1:0];
                  state_ff   <= S_INC_ADD;
               end
            end

            S_INC_ADD: begin
               integ_ff <= integ_add;
               state_ff <= S_CAP;
            end

            // Cap so that the integral term stays within 100 percent.
            S_CAP: begin
               if (ki_sel != '0 && integ_ff != '0 &&
                   ki_sel[DATA_W-1] == integ_ff[INTEG_W-1]) begin
                  div_start_ff <= 1'b1;
                  div_n_ff     <= Q32_100;
                  div_d_ff     <= ki_abs;
                  state_ff     <= S_CAP_DIV;
               end else begin
                  state_ff <= S_UNI;
               end
            end

            S_CAP_DIV: begin
               if (div_done) begin
                  if ({16'd0, integ_abs} > div_q) begin
                     integ_ff <= ki_sel[DATA_W-1] ? -$signed(div_q[INTEG_W-1:0])
                                                  : $signed(div_q[INTEG_W-1:0]);
                  end
                  state_ff <= S_UNI;
               end
            end

            // A unipolar load cannot use an integral of the wrong sign.
            S_UNI: begin
               if (!bipolar && integ_ff != '0 &&
                   ((!fmode && !integ_ff[INTEG_W-1]) ||
                    (fmode && integ_ff[INTEG_W-1]))) begin
                  integ_ff <= '0;
               end
               state_ff <= S_DER;
            end

            // Derivative, normalized by the interval.
            S_DER: begin
               mul_start_ff <= 1'b1;
               if (dt_ff != '0) begin
                  mul_a_ff <= nrm_ff;
                  mul_b_ff <= {15'd0, dmag};
                  mneg_ff  <= ddiff[32];
                  state_ff <= S_DER_MUL;
               end else begin
                  der_ff   <= '0;
                  mul_a_ff <= kp_abs;
                  mul_b_ff <= {16'd0, err_abs};
                  mneg_ff  <= kp_sel[DATA_W-1] ^ err_ff[DATA_W-1];
                  state_ff <= S_KP;
               end
            end

            S_DER_MUL: begin
               if (mul_done) begin
                  div_start_ff <= 1'b1;
                  div_n_ff     <= mul_p[DIV_N_W-1:0];
                  div_d_ff     <= dt_ff;
                  state_ff     <= S_DER_DIV;
               end
            end

            S_DER_DIV: begin
               if (div_done) begin
                  if (div_q > {16'd0, MAG47_M1}) begin
                     der_ff <= mneg_ff ? -$signed(MAG47_M1) : $signed(MAG47_M1);
                  end else begin
                     der_ff <= mneg_ff ? -$signed(div_q[INTEG_W-1:0])
                                       : $signed(div_q[INTEG_W-1:0]);
                  end
                  mul_start_ff <= 1'b1;
                  mul_a_ff     <= kp_abs;
                  mul_b_ff     <= {16'd0, err_abs};
                  mneg_ff      <= kp_sel[DATA_W-1] ^ err_ff[DATA_W-1];
                  state_ff     <= S_KP;
               end
            end

            // Sum of the three saturated gain products.
            S_KP: begin
               if (mul_done) begin
                  acc_ff       <= prod_sat;
                  mul_start_ff <= 1'b1;
                  mul_a_ff     <= ki_abs;
                  mul_b_ff     <= integ_abs;
                  mneg_ff      <= ki_sel[DATA_W-1] ^ integ_ff[INTEG_W-1];
                  state_ff     <= S_KI;
               end
            end

            S_KI: begin
               if (mul_done) begin
                  acc_ff       <= acc_ff + prod_sat;
                  mul_start_ff <= 1'b1;
                  mul_a_ff     <= kd_abs;
                  mul_b_ff     <= der_abs;
                  mneg_ff      <= kd_sel[DATA_W-1] ^ der_ff[INTEG_W-1];
                  state_ff     <= S_KD;
               end
            end

            S_KD: begin
               if (mul_done) begin
                  acc_ff   <= acc_ff + prod_sat;
                  state_ff <= S_SUM;
               end
            end

            // Drive value and channel state update.
            S_SUM: begin
               res_drive_ff       <= drive_val;
               res_status_ff      <= ST_NORMAL;
               integ_st_ff[ch_ff] <= integ_ff;
               norm_st_ff[ch_ff]  <= nrm_ff;
               ptime_st_ff[ch_ff] <= now_ff;
               perr_st_ff[ch_ff]  <= err_ff;
               state_ff           <= S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_drive_ff  <= res_drive_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = rsp_drive_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/core/dcpid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpid_checker
// Port-level checks of the dual-channel PID controller.
// ----------------------------------------------------------------------------
module dcpid_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [dcpid_pkg::DRIVE_W-1:0] rsp_drive,
   input logic        [1:0]                    rsp_status
);
   import dcpid_pkg::*;

   // One item at a time: an accepted item blocks the next one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while the previous one was in work");

   // Only a normal result carries a nonzero drive.
   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_NORMAL) |-> (rsp_drive == '0))
      else $error("nonzero drive on a primed, no-frequency or reset result");

   // Drive stays within plus or minus 100 percent.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= 16'sd25600 && rsp_drive >= -16'sd25600))
      else $error("drive outside the output limit");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_drive) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind dual_channel_pid_with_glitch_filter dcpid_checker u_dcpid_checker (.*);
